>>> src/tcw_pkg.sv
// Package for the whitespace cleaner: transaction structs, code point constants
// and the code point classification functions.
// No dependencies.
package tcw_pkg;

  localparam int unsigned CP_W = 21;

  // code point constants
  localparam logic [CP_W-1:0] CP_SPACE       = 21'h00020;
  localparam logic [CP_W-1:0] CP_NEL         = 21'h00085;
  localparam logic [CP_W-1:0] CP_NBSP        = 21'h000A0;
  localparam logic [CP_W-1:0] CP_OGHAM_SP    = 21'h01680;
  localparam logic [CP_W-1:0] CP_LINE_SEP    = 21'h02028;
  localparam logic [CP_W-1:0] CP_PARA_SEP    = 21'h02029;
  localparam logic [CP_W-1:0] CP_NNBSP       = 21'h0202F;
  localparam logic [CP_W-1:0] CP_MMSP        = 21'h0205F;
  localparam logic [CP_W-1:0] CP_IDEO_SP     = 21'h03000;
  localparam logic [CP_W-1:0] CP_BOM         = 21'h0FEFF;
  localparam logic [CP_W-1:0] CP_DEL         = 21'h0007F;
  localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h0DFFF;
  localparam logic [CP_W-1:0] CP_GEN_SP_LO   = 21'h02000;
  localparam logic [CP_W-1:0] CP_GEN_SP_HI   = 21'h0200A;
  localparam logic [CP_W-1:0] CP_CJK_URO_LO  = 21'h04E00;
  localparam logic [CP_W-1:0] CP_CJK_URO_HI  = 21'h09FFF;

  // one input transaction
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [CP_W-1:0] out_point;
    logic            has_char;
    logic            end_of_text;
    logic            empty_error;
  } out_item_t;

  // command from the front to the back: a result, optionally preceded by a space
  typedef struct packed {
    out_item_t item;
    logic      space;
  } cmd_t;

  function automatic logic in_rng(input logic [CP_W-1:0] c, input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    in_rng = (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_blank(input logic [CP_W-1:0] c);
    is_blank = (c == CP_SPACE) || in_rng(c, 21'h09, 21'h0D) || in_rng(c, 21'h1C, 21'h1E) ||
               (c == CP_NEL) || (c == CP_NBSP) || (c == CP_OGHAM_SP) ||
               (c == CP_LINE_SEP) || (c == CP_PARA_SEP) || (c == CP_NNBSP) ||
               (c == CP_MMSP) || (c == CP_IDEO_SP) || in_rng(c, CP_GEN_SP_LO, CP_GEN_SP_HI);
  endfunction

  function automatic logic is_break(input logic [CP_W-1:0] c);
    is_break = in_rng(c, 21'h0A, 21'h0D) || in_rng(c, 21'h1C, 21'h1E) ||
               (c == CP_NEL) || (c == CP_LINE_SEP) || (c == CP_PARA_SEP);
  endfunction

  // meaningful only for code points that are not whitespace
  function automatic logic is_control(input logic [CP_W-1:0] c);
    is_control = (c <= 21'h1F) || in_rng(c, CP_DEL, 21'h9F) ||
                 in_rng(c, 21'h200B, 21'h200F) || in_rng(c, 21'h202A, 21'h202E) ||
                 in_rng(c, 21'h2060, 21'h206F) || (c == CP_BOM) ||
                 in_rng(c, CP_SURR_LO, CP_SURR_HI);
  endfunction

  function automatic logic is_cjk(input logic [CP_W-1:0] c);
    is_cjk = in_rng(c, 21'h01100, 21'h011FF) || in_rng(c, 21'h02E80, 21'h02FDF) ||
             in_rng(c, 21'h03000, 21'h031FF) || in_rng(c, 21'h03400, 21'h04DBF) ||
             in_rng(c, CP_CJK_URO_LO, CP_CJK_URO_HI) || in_rng(c, 21'h0A960, 21'h0A97F) ||
             in_rng(c, 21'h0AC00, 21'h0D7A3) || in_rng(c, 21'h0D7B0, 21'h0D7FF) ||
             in_rng(c, 21'h0F900, 21'h0FAFF) || in_rng(c, 21'h0FE30, 21'h0FE4F) ||
             in_rng(c, 21'h0FF01, 21'h0FF9F) || in_rng(c, 21'h20000, 21'h2FA1F);
  endfunction

endpackage

>>> src/tcw_front.sv
// Front end of the whitespace cleaner: classifies each accepted code point,
// tracks the run state and issues commands to the back end.
// Depends on tcw_pkg.
module tcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  tcw_pkg::in_item_t in_data,
  output logic             cmd_push,
  output tcw_pkg::cmd_t    cmd_data
);

  logic seen_text_r, seen_text_nxt;
  logic in_run_r, in_run_nxt;
  logic run_brk_r, run_brk_nxt;
  logic prev_cjk_r, prev_cjk_nxt;

  logic [tcw_pkg::CP_W-1:0] cp;
  logic sp, brk, ctrl, kept, cjk;

  // classification
  always_comb begin
    cp   = in_data.code_point;
    sp   = tcw_pkg::is_blank(cp);
    brk  = tcw_pkg::is_break(cp);
    ctrl = tcw_pkg::is_control(cp);
    cjk  = tcw_pkg::is_cjk(cp);
    kept = !sp && !ctrl;
  end

  // command toward the back end
  always_comb begin
    cmd_push = accept && (kept || in_data.last);
    cmd_data.space = kept && seen_text_r && in_run_r && !(run_brk_r && prev_cjk_r && cjk);
    cmd_data.item.out_point   = kept ? cp : '0;
    cmd_data.item.has_char    = kept;
    cmd_data.item.end_of_text = in_data.last;
    cmd_data.item.empty_error = !kept && !seen_text_r;
  end

  // run state update
  always_comb begin
    seen_text_nxt = seen_text_r;
    in_run_nxt    = in_run_r;
    run_brk_nxt   = run_brk_r;
    prev_cjk_nxt  = prev_cjk_r;
    if (accept) begin
      if (in_data.last) begin
        seen_text_nxt = 1'b0;
        in_run_nxt    = 1'b0;
        run_brk_nxt   = 1'b0;
        prev_cjk_nxt  = 1'b0;
      end else if (kept) begin
        seen_text_nxt = 1'b1;
        in_run_nxt    = 1'b0;
        run_brk_nxt   = 1'b0;
        prev_cjk_nxt  = cjk;
      end else if (sp && seen_text_r) begin
        in_run_nxt  = 1'b1;
        run_brk_nxt = run_brk_r | brk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_text_r <= 1'b0;
      in_run_r    <= 1'b0;
      run_brk_r   <= 1'b0;
      prev_cjk_r  <= 1'b0;
    end else begin
      seen_text_r <= seen_text_nxt;
      in_run_r    <= in_run_nxt;
      run_brk_r   <= run_brk_nxt;
      prev_cjk_r  <= prev_cjk_nxt;
    end
  end

endmodule

>>> src/tcw_queue.sv
// Short command queue between the front and back ends of the whitespace cleaner.
// Depends on tcw_pkg.
module tcw_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tcw_pkg::cmd_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tcw_pkg::cmd_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/tcw_back.sv
// Back end of the whitespace cleaner: expands each command into its result, preceded
// by a space when asked, and holds the oldest result in the output register.
// Depends on tcw_pkg.
module tcw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tcw_pkg::cmd_t     q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output tcw_pkg::out_item_t out_data
);

  logic               cmd_valid_r, cmd_valid_nxt;
  logic               space_pend_r, space_pend_nxt;
  tcw_pkg::out_item_t cmd_r, cmd_nxt;
  logic               out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t out_r, out_nxt;
  logic               load, cmd_done;
  tcw_pkg::out_item_t space_item;

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    space_item.out_point   = tcw_pkg::CP_SPACE;
    space_item.has_char    = 1'b1;
    space_item.end_of_text = 1'b0;
    space_item.empty_error = 1'b0;
  end

  // result selection and command refill
  always_comb begin
    load           = !out_valid_r || pop;
    cmd_done       = load && cmd_valid_r && !space_pend_r;
    q_pop          = q_valid && (!cmd_valid_r || cmd_done);
    out_valid_nxt  = out_valid_r && !pop;
    out_nxt        = out_r;
    cmd_valid_nxt  = cmd_valid_r;
    space_pend_nxt = space_pend_r;
    cmd_nxt        = cmd_r;
    if (load && cmd_valid_r) begin
      out_valid_nxt = 1'b1;
      if (space_pend_r) begin
        out_nxt        = space_item;
        space_pend_nxt = 1'b0;
      end else begin
        out_nxt       = cmd_r;
        cmd_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cmd_valid_nxt  = 1'b1;
      space_pend_nxt = q_data.space;
      cmd_nxt        = q_data.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r  <= 1'b0;
      space_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cmd_valid_r  <= cmd_valid_nxt;
      space_pend_r <= space_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

endmodule

>>> src/text_clean_whitespace_cjk.sv
// Top level of the whitespace cleaner: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// Usage: code points enter through a queue-style port (push/full, in_data);
// set in_data.last on the final code point of a text. Results leave through a
// queue-style port (empty/pop, out_data): the oldest result is shown while
// empty is low and is taken when pop is high.
// A kept code point gives its own result, preceded by a space when a
// whitespace run lies between it and the previous kept character (dropped
// for a run with a line break between two CJK characters). A last input that
// is not kept gives a bare end marker, with empty_error set if nothing was kept.
// Each command passes the queue and the back end's command register before its
// result is registered in the output register, behind any space it brings.
// Throughput: one input per cycle is accepted while the queue has room; the
// back end delivers one result per cycle while the receiver pops, so an input
// that yields a space and a character uses the output for both of its results.
// Reset clears the run state, the queue and the output register.
// When the receiver stalls, the output register holds, the queue fills and
// full rises after QUEUE_DEPTH commands are waiting.
module text_clean_whitespace_cjk #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tcw_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output tcw_pkg::out_item_t out_data
);

  logic          accept;
  logic          cmd_push;
  tcw_pkg::cmd_t cmd_data;
  logic          q_valid;
  logic          q_pop;
  tcw_pkg::cmd_t q_data;

  assign accept = push && !full;

  // classify and track run state
  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd_data (cmd_data)
  );

  // decoupling queue
  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  // expand commands into results
  tcw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> sim/tb.sv
// Testbench for text_clean_whitespace_cjk: directed and random code point texts,
// each result checked against a behavioral whitespace cleaner kept in the bench.
// Depends on tcw_pkg and the text_clean_whitespace_cjk RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [tcw_pkg::CP_W-1:0] cp_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  tcw_pkg::in_item_t  in_data = '0;
  tcw_pkg::out_item_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;

  // cleaned results still to come out of the block, oldest first
  tcw_pkg::out_item_t cleaned_results[$];
  tcw_pkg::out_item_t oldest_result;

  // state of the behavioral cleaner
  bit kept_any;
  bit ws_pending;
  bit ws_has_break;
  bit last_was_cjk;

  text_clean_whitespace_cjk dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // code point classes
  function automatic bit between(input cp_t c, input int unsigned lo,
                                 input int unsigned hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic bit ws_point(input cp_t c);
    case (c)
      tcw_pkg::CP_SPACE, tcw_pkg::CP_NEL, tcw_pkg::CP_NBSP, tcw_pkg::CP_OGHAM_SP,
      tcw_pkg::CP_LINE_SEP, tcw_pkg::CP_PARA_SEP, tcw_pkg::CP_NNBSP,
      tcw_pkg::CP_MMSP, tcw_pkg::CP_IDEO_SP: return 1'b1;
      default: return between(c, 'h09, 'h0D) || between(c, 'h1C, 'h1E) ||
                      between(c, tcw_pkg::CP_GEN_SP_LO, tcw_pkg::CP_GEN_SP_HI);
    endcase
  endfunction

  function automatic bit break_point(input cp_t c);
    return between(c, 'h0A, 'h0D) || between(c, 'h1C, 'h1E) || c == tcw_pkg::CP_NEL ||
           c == tcw_pkg::CP_LINE_SEP || c == tcw_pkg::CP_PARA_SEP;
  endfunction

  // only asked for code points that are not whitespace
  function automatic bit hidden_point(input cp_t c);
    return c <= 'h1F || between(c, tcw_pkg::CP_DEL, 'h9F) || between(c, 'h200B, 'h200F) ||
           between(c, 'h202A, 'h202E) || between(c, 'h2060, 'h206F) ||
           c == tcw_pkg::CP_BOM || between(c, tcw_pkg::CP_SURR_LO, tcw_pkg::CP_SURR_HI);
  endfunction

  function automatic bit cjk_point(input cp_t c);
    return between(c, 'h1100, 'h11FF) || between(c, 'h2E80, 'h2FDF) ||
           between(c, 'h3000, 'h31FF) || between(c, 'h3400, 'h4DBF) ||
           between(c, tcw_pkg::CP_CJK_URO_LO, tcw_pkg::CP_CJK_URO_HI) ||
           between(c, 'hA960, 'hA97F) ||
           between(c, 'hAC00, 'hD7A3) || between(c, 'hD7B0, 'hD7FF) ||
           between(c, 'hF900, 'hFAFF) || between(c, 'hFE30, 'hFE4F) ||
           between(c, 'hFF01, 'hFF9F) || between(c, 'h20000, 'h2FA1F);
  endfunction

  // append one expected result at the tail
  function automatic void expect_result(input cp_t pt, input bit has, input bit eot,
                                        input bit err);
    tcw_pkg::out_item_t r;
    r.out_point   = pt;
    r.has_char    = has;
    r.end_of_text = eot;
    r.empty_error = err;
    cleaned_results.insert(cleaned_results.size(), r);
  endfunction

  // work out the results of one accepted code point
  function automatic void predict_clean(input tcw_pkg::in_item_t it);
    cp_t c;
    bit cjk;
    bit kept;
    c = it.code_point;
    cjk = cjk_point(c);
    kept = 1'b0;
    if (ws_point(c)) begin
      if (kept_any) begin
        ws_pending = 1'b1;
        if (break_point(c)) ws_has_break = 1'b1;
      end
    end else if (!hidden_point(c)) begin
      // space only between kept characters, not across a break between cjk ones
      if (kept_any && ws_pending && !(ws_has_break && last_was_cjk && cjk))
        expect_result(tcw_pkg::CP_SPACE, 1'b1, 1'b0, 1'b0);
      expect_result(c, 1'b1, it.last, 1'b0);
      kept = 1'b1;
      kept_any = 1'b1;
      ws_pending = 1'b0;
      ws_has_break = 1'b0;
      last_was_cjk = cjk;
    end
    // bare end marker when the last code point is not kept
    if (it.last && !kept)
      expect_result('0, 1'b0, 1'b1, !kept_any);
    if (it.last) begin
      kept_any = 1'b0;
      ws_pending = 1'b0;
      ws_has_break = 1'b0;
      last_was_cjk = 1'b0;
    end
  endfunction

  // random result side stalls
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_field(input string name, input cp_t want, input cp_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  // check each result transaction against the oldest expected one
  always @(negedge clk) begin
    if (rst_n && pop && !empty) begin
      if (cleaned_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_data);
      end else begin
        oldest_result = cleaned_results.pop_front();
        report_field("out_point", oldest_result.out_point, out_data.out_point);
        report_field("has_char", oldest_result.has_char, out_data.has_char);
        report_field("end_of_text", oldest_result.end_of_text, out_data.end_of_text);
        report_field("empty_error", oldest_result.empty_error, out_data.empty_error);
      end
    end
  end

  // send one code point; returns at the edge that accepts it
  task automatic send_point(input cp_t cp, input logic lst);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= '{cp, lst};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      if (taken) predict_clean(in_data);
      @(posedge clk);
    end
  endtask

  // hold the sender until every expected result has come out
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (cleaned_results.size() != 0) @(posedge clk);
  endtask

  // code points near class boundaries and at the field extremes
  function automatic cp_t boundary_point();
    case ($urandom_range(19))
      0: return 21'h000008;
      1: return 21'h00000E;
      2: return 21'h00001B;
      3: return 21'h00001F;
      4: return 21'h000021;
      5: return 21'h00007E;
      6: return 21'h0000A1;
      7: return 21'h0010FF;
      8: return 21'h0011FF;
      9: return 21'h002E7F;
      10: return 21'h002FE0;
      11: return 21'h003200;
      12: return 21'h00A000;
      13: return 21'h00D7A4;
      14: return 21'h00E000;
      15: return 21'h00FFA0;
      16: return 21'h02FA20;
      17: return 21'h10FFFF;
      18: return 21'h110000;
      default: return 21'h1FFFFF;
    endcase
  endfunction

  // one random code point; cjk_bias favors cjk text with line breaks
  function automatic cp_t pick_code_point(input bit cjk_bias);
    int unsigned cls;
    cls = cjk_bias ? $urandom_range(5, 9) : $urandom_range(0, 11);
    case (cls)
      0, 1, 2: return cp_t'(21'h21 + $urandom_range(93));
      3: return cp_t'(21'hA0 + $urandom_range(21'h1FFF));
      4: return boundary_point();
      5, 6: begin
        case ($urandom_range(4))
          0: return cp_t'(tcw_pkg::CP_CJK_URO_LO + $urandom_range(21'h51FF));
          1: return cp_t'(21'hAC00 + $urandom_range(21'h2BA3));
          2: return cp_t'(21'h20000 + $urandom_range(21'hFA1F));
          3: return cp_t'(21'h3001 + $urandom_range(21'h1FE));
          default: return cp_t'(21'hFF01 + $urandom_range(21'h9E));
        endcase
      end
      7: begin
        case ($urandom_range(5))
          0: return cp_t'(21'h0A + $urandom_range(3));
          1: return cp_t'(21'h1C + $urandom_range(2));
          2: return tcw_pkg::CP_NEL;
          3: return tcw_pkg::CP_LINE_SEP;
          4: return tcw_pkg::CP_PARA_SEP;
          default: return tcw_pkg::CP_IDEO_SP;
        endcase
      end
      8: begin
        case ($urandom_range(6))
          0: return tcw_pkg::CP_SPACE;
          1: return 21'h09;
          2: return tcw_pkg::CP_NBSP;
          3: return tcw_pkg::CP_OGHAM_SP;
          4: return cp_t'(tcw_pkg::CP_GEN_SP_LO + $urandom_range(10));
          5: return tcw_pkg::CP_NNBSP;
          default: return tcw_pkg::CP_MMSP;
        endcase
      end
      9: begin
        case ($urandom_range(6))
          0: return cp_t'($urandom_range(8));
          1: return cp_t'(tcw_pkg::CP_DEL + $urandom_range(32));
          2: return cp_t'(21'h200B + $urandom_range(4));
          3: return cp_t'(21'h202A + $urandom_range(4));
          4: return cp_t'(21'h2060 + $urandom_range(15));
          5: return tcw_pkg::CP_BOM;
          default: return cp_t'(tcw_pkg::CP_SURR_LO + $urandom_range(21'h7FF));
        endcase
      end
      default: return cp_t'($urandom);
    endcase
  endfunction

  // extremes, every class of code point and each end-of-text case
  task automatic test_directed_cases();
    // leading whitespace, then cjk across a line break: no space
    send_point(tcw_pkg::CP_IDEO_SP, 1'b0);
    send_point(21'h09, 1'b0);
    send_point(tcw_pkg::CP_CJK_URO_LO, 1'b0);
    send_point(tcw_pkg::CP_LINE_SEP, 1'b0);
    send_point(tcw_pkg::CP_SPACE, 1'b0);
    send_point(tcw_pkg::CP_CJK_URO_HI, 1'b0);
    // break between cjk and latin keeps the space
    send_point(21'h0D, 1'b0);
    send_point(21'h41, 1'b0);
    // dropped controls and surrogates do not open a run
    send_point(21'h00, 1'b0);
    send_point(tcw_pkg::CP_DEL, 1'b0);
    send_point(tcw_pkg::CP_BOM, 1'b0);
    send_point(tcw_pkg::CP_SURR_LO, 1'b0);
    send_point(tcw_pkg::CP_SURR_HI, 1'b0);
    send_point(21'h200B, 1'b0);
    // run of plain whitespace, then an out-of-range code point
    send_point(tcw_pkg::CP_GEN_SP_HI, 1'b0);
    send_point(21'h1FFFFF, 1'b0);
    // trailing whitespace as the last code point
    send_point(tcw_pkg::CP_NEL, 1'b1);
    // text of whitespace only
    send_point(21'h0C, 1'b1);
    // single kept code point just above the unicode range
    send_point(21'h110000, 1'b1);
    // cjk, a space without a break, cjk: space kept
    send_point(21'hAC00, 1'b0);
    send_point(tcw_pkg::CP_SPACE, 1'b0);
    send_point(21'h20000, 1'b1);
    // text of one dropped control
    send_point(21'h200B, 1'b1);
    wait_drained();
  endtask

  // random texts with random idling, pausing now and then until drained
  task automatic test_random_phase(input int unsigned s_pct, input int unsigned r_pct,
                                   input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit cjk_bias;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      cjk_bias = ($urandom_range(3) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(99) == 0) wait_drained();
        send_point(pick_code_point(cjk_bias), i == len - 1);
        sent++;
      end
    end
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 45;
    test_directed_cases();
    test_random_phase(15, 45, 700);
    test_random_phase(45, 15, 700);
    test_random_phase(0, 0, 600);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_clean_whitespace_cjk.sv
sim/tb.sv
